/* sv/vpr_pkg.sv */
// Package for the viewport pixel-to-ray core: widths, register codes and
// configuration bundle types. No dependencies.
`default_nettype none
package vpr_pkg;

   localparam int DEFAULT_COORD_BITS = 12;
   localparam int CSR_DATA_BITS      = 32;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int INTR_BITS          = 32;   // Q4.28 intrinsics
   localparam int TRIG_BITS          = 18;   // Q1.16 cosines and sines
   localparam int SLOPE_BITS         = 24;   // Q.16 ray slope
   localparam int RAD_BITS           = 48;   // squared length, units 2^-32
   localparam int ROOT_BITS          = 24;   // Q.16 length
   localparam int QUOT_BITS          = 17;   // unsigned unit component
   localparam int NUM_BITS           = 40;   // dividend width
   localparam int COMP_BITS          = 18;   // signed unit component
   localparam int COEF_BITS          = 36;   // Q.32 matrix entry
   localparam int ACC_BITS           = 64;
   localparam int DIR_BITS           = 16;
   localparam int DIR_MAX            = 16384;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_INV_SCALE_X = 3'd0,
      REG_OFFSET_X    = 3'd1,
      REG_INV_SCALE_Y = 3'd2,
      REG_OFFSET_Y    = 3'd3,
      REG_COS_YAW     = 3'd4,
      REG_SIN_YAW     = 3'd5,
      REG_COS_PITCH   = 3'd6,
      REG_SIN_PITCH   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [INTR_BITS-1:0] inv_scale_x;
      logic signed [INTR_BITS-1:0] offset_x;
      logic signed [INTR_BITS-1:0] inv_scale_y;
      logic signed [INTR_BITS-1:0] offset_y;
   } intr_cfg_type;

   typedef struct packed {
      logic signed [TRIG_BITS-1:0] cos_yaw;
      logic signed [TRIG_BITS-1:0] sin_yaw;
      logic signed [TRIG_BITS-1:0] cos_pitch;
      logic signed [TRIG_BITS-1:0] sin_pitch;
   } rot_cfg_type;

endpackage
`default_nettype wire

/* sv/viewport_pixel_to_ray_core.sv */
// Top level of the viewport pixel-to-ray core: configuration registers and
// the pipeline. Depends on vpr_pkg, vpr_front, vpr_sqrt, vpr_div, vpr_rotate.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_pixel_x, req_pixel_y
//   rsp      out        rsp_valid/stall    rsp_dir_x, rsp_dir_y, rsp_dir_z
//   csr      in         csr_wr_en          csr_index, csr_data
//
// One pixel enters per cycle unless the pipeline holds; each result passes through
// 4 front stages, 24 square-root stages, 17 divider stages and 3 rotation stages.
// The whole pipeline advances together; it holds while a result sits unclaimed.
// Reset clears the valid chain and loads the identity rotation and zero intrinsics.
`default_nettype none
module viewport_pixel_to_ray_core import vpr_pkg::*; #(
   parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [COORD_BITS-1:0]         req_pixel_x,
   input  wire logic [COORD_BITS-1:0]         req_pixel_y,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [DIR_BITS-1:0]         rsp_dir_x,
   output logic signed [DIR_BITS-1:0]         rsp_dir_y,
   output logic signed [DIR_BITS-1:0]         rsp_dir_z,
   input  wire logic                          csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_data
);
   intr_cfg_type intr_ff;
   rot_cfg_type  rot_ff;
   logic en;
   logic fr_valid, sq_valid, dv_valid;
   logic signed [SLOPE_BITS-1:0] fr_x2, fr_y2, sq_x2, sq_y2;
   logic [RAD_BITS-1:0] fr_rad;
   logic [ROOT_BITS-1:0] sq_root;
   logic signed [COMP_BITS-1:0] dv_x1, dv_y1, dv_z1;

   // advance unless a finished result is held
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         intr_ff          <= '0;
         rot_ff.cos_yaw   <= TRIG_BITS'(65536);
         rot_ff.sin_yaw   <= '0;
         rot_ff.cos_pitch <= TRIG_BITS'(65536);
         rot_ff.sin_pitch <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_INV_SCALE_X: intr_ff.inv_scale_x <= csr_data;
            REG_OFFSET_X:    intr_ff.offset_x    <= csr_data;
            REG_INV_SCALE_Y: intr_ff.inv_scale_y <= csr_data;
            REG_OFFSET_Y:    intr_ff.offset_y    <= csr_data;
            REG_COS_YAW:     rot_ff.cos_yaw      <= csr_data[TRIG_BITS-1:0];
            REG_SIN_YAW:     rot_ff.sin_yaw      <= csr_data[TRIG_BITS-1:0];
            REG_COS_PITCH:   rot_ff.cos_pitch    <= csr_data[TRIG_BITS-1:0];
            REG_SIN_PITCH:   rot_ff.sin_pitch    <= csr_data[TRIG_BITS-1:0];
            default: ;
         endcase
      end
   end

   vpr_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .en,
      .in_valid  (req_valid && !req_stall),
      .pixel_x   (req_pixel_x),
      .pixel_y   (req_pixel_y),
      .intr      (intr_ff),
      .out_valid (fr_valid),
      .x2        (fr_x2),
      .y2        (fr_y2),
      .rad       (fr_rad)
   );

   vpr_sqrt u_sqrt (
      .clock, .reset, .en,
      .in_valid  (fr_valid),
      .x2        (fr_x2),
      .y2        (fr_y2),
      .rad       (fr_rad),
      .out_valid (sq_valid),
      .x2_out    (sq_x2),
      .y2_out    (sq_y2),
      .root      (sq_root)
   );

   vpr_div u_div (
      .clock, .reset, .en,
      .in_valid  (sq_valid),
      .x2        (sq_x2),
      .y2        (sq_y2),
      .root      (sq_root),
      .out_valid (dv_valid),
      .x1        (dv_x1),
      .y1        (dv_y1),
      .z1        (dv_z1)
   );

   vpr_rotate u_rotate (
      .clock, .reset, .en,
      .in_valid  (dv_valid),
      .x1        (dv_x1),
      .y1        (dv_y1),
      .z1        (dv_z1),
      .rot       (rot_ff),
      .out_valid (rsp_valid),
      .dir_x     (rsp_dir_x),
      .dir_y     (rsp_dir_y),
      .dir_z     (rsp_dir_z)
   );

   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not track held result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dir_x <= 16'sd16384 && rsp_dir_x >= -16'sd16384 &&
                     rsp_dir_z <= 16'sd16384 && rsp_dir_z >= -16'sd16384))
      else $error("direction outside unit clamp");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_dir_y)))
      else $error("held result changed");
endmodule
`default_nettype wire

/* sv/vpr_front.sv */
// Front stages: pixel center through inverse intrinsics, slope rounding and
// clamp, squares and squared ray length. Depends on vpr_pkg.
`default_nettype none
module vpr_front import vpr_pkg::*; #(
   parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic [COORD_BITS-1:0]         pixel_x,
   input  wire logic [COORD_BITS-1:0]         pixel_y,
   input  wire intr_cfg_type                  intr,
   output logic                               out_valid,
   output logic signed [SLOPE_BITS-1:0]       x2,
   output logic signed [SLOPE_BITS-1:0]       y2,
   output logic [RAD_BITS-1:0]                rad
);
   localparam int WW = INTR_BITS + COORD_BITS + 3;

   logic [3:0] valid_ff;
   logic signed [WW-1:0] wx_in, wy_in, wx_ff, wy_ff;
   logic signed [WW-1:0] rx, ry;
   logic signed [SLOPE_BITS-1:0] x2a_in, y2a_in, x2a_ff, y2a_ff, x2b_ff, y2b_ff;
   logic signed [2*SLOPE_BITS-1:0] sqx_in, sqy_in;
   logic [2*SLOPE_BITS-1:0] sqx_ff, sqy_ff;
   logic [RAD_BITS-1:0] rad_in, rad_ff;
   logic signed [SLOPE_BITS-1:0] x2c_ff, y2c_ff;

   function automatic logic signed [SLOPE_BITS-1:0] sat(input logic signed [WW-1:0] v);
      logic signed [WW-1:0] hi, lo;
      hi = WW'(signed'({1'b0, {(SLOPE_BITS-1){1'b1}}}));
      lo = -hi - WW'(1);
      if (v > hi) return hi[SLOPE_BITS-1:0];
      else if (v < lo) return lo[SLOPE_BITS-1:0];
      else return v[SLOPE_BITS-1:0];
   endfunction

   // scale times doubled center plus doubled offset
   assign wx_in = WW'(intr.inv_scale_x) * WW'($signed({1'b0, pixel_x, 1'b1}))
                + (WW'(intr.offset_x) <<< 1);
   assign wy_in = WW'(intr.inv_scale_y) * WW'($signed({1'b0, pixel_y, 1'b1}))
                + (WW'(intr.offset_y) <<< 1);

   // round half up to Q.16 and saturate
   assign rx = (wx_ff + WW'(4096)) >>> 13;
   assign ry = (wy_ff + WW'(4096)) >>> 13;
   assign x2a_in = sat(rx);
   assign y2a_in = sat(ry);

   assign sqx_in = x2a_ff * x2a_ff;
   assign sqy_in = y2a_ff * y2a_ff;
   assign rad_in = RAD_BITS'(sqx_ff) + RAD_BITS'(sqy_ff) + (RAD_BITS'(1) << 32);

   // advance the valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // advance the data
   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff  <= wx_in;
         wy_ff  <= wy_in;
         x2a_ff <= x2a_in;
         y2a_ff <= y2a_in;
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         x2b_ff <= x2a_ff;
         y2b_ff <= y2a_ff;
         rad_ff <= rad_in;
         x2c_ff <= x2b_ff;
         y2c_ff <= y2b_ff;
      end
   end

   assign out_valid = valid_ff[3];
   assign x2  = x2c_ff;
   assign y2  = y2c_ff;
   assign rad = rad_ff;
endmodule
`default_nettype wire

/* sv/vpr_sqrt.sv */
// Square root pipeline: one root bit per stage, digit by digit, with the
// slopes carried alongside. Depends on vpr_pkg.
`default_nettype none
module vpr_sqrt import vpr_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic signed [SLOPE_BITS-1:0]  x2,
   input  wire logic signed [SLOPE_BITS-1:0]  y2,
   input  wire logic [RAD_BITS-1:0]           rad,
   output logic                               out_valid,
   output logic signed [SLOPE_BITS-1:0]       x2_out,
   output logic signed [SLOPE_BITS-1:0]       y2_out,
   output logic [ROOT_BITS-1:0]               root
);
   localparam int REM_BITS = ROOT_BITS + 2;

   logic                          valid_ff [0:ROOT_BITS];
   logic [REM_BITS-1:0]           rem_ff   [0:ROOT_BITS];
   logic [ROOT_BITS-1:0]          root_ff  [0:ROOT_BITS];
   logic [RAD_BITS-1:0]           rad_ff   [0:ROOT_BITS];
   logic signed [SLOPE_BITS-1:0]  x_ff     [0:ROOT_BITS];
   logic signed [SLOPE_BITS-1:0]  y_ff     [0:ROOT_BITS];

   // stage zero is the unregistered entry
   assign valid_ff[0] = in_valid;
   assign rem_ff[0]   = '0;
   assign root_ff[0]  = '0;
   assign rad_ff[0]   = rad;
   assign x_ff[0]     = x2;
   assign y_ff[0]     = y2;

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      logic [REM_BITS-1:0]  rem_t, trial, rem_in;
      logic [ROOT_BITS-1:0] root_in;

      // bring down two bits and try the next root bit
      always_comb begin
         rem_t = {rem_ff[k][REM_BITS-3:0], rad_ff[k][RAD_BITS-1 -: 2]};
         trial = {root_ff[k], 2'b01};
         if (rem_t >= trial) begin
            rem_in  = rem_t - trial;
            root_in = {root_ff[k][ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_t;
            root_in = {root_ff[k][ROOT_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
            rad_ff[k+1]  <= rad_ff[k] << 2;
            x_ff[k+1]    <= x_ff[k];
            y_ff[k+1]    <= y_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_BITS];
   assign root      = root_ff[ROOT_BITS];
   assign x2_out    = x_ff[ROOT_BITS];
   assign y2_out    = y_ff[ROOT_BITS];

   // the length never drops below one
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> root[ROOT_BITS-1:16] != '0)
      else $error("ray length below one");
endmodule
`default_nettype wire

/* sv/vpr_div.sv */
// Three-lane restoring divider pipeline, one quotient bit per stage, giving
// the normalized ray x, y and z. Depends on vpr_pkg.
`default_nettype none
module vpr_div import vpr_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic signed [SLOPE_BITS-1:0]  x2,
   input  wire logic signed [SLOPE_BITS-1:0]  y2,
   input  wire logic [ROOT_BITS-1:0]          root,
   output logic                               out_valid,
   output logic signed [COMP_BITS-1:0]        x1,
   output logic signed [COMP_BITS-1:0]        y1,
   output logic signed [COMP_BITS-1:0]        z1
);
   localparam int LANES = 3;
   localparam int RBITS = NUM_BITS + 1;

   logic                   valid_ff [0:QUOT_BITS];
   logic [RBITS-1:0]       rem_ff   [0:QUOT_BITS][LANES];
   logic [QUOT_BITS-1:0]   quo_ff   [0:QUOT_BITS][LANES];
   logic [LANES-1:0]       neg_ff   [0:QUOT_BITS];
   logic [ROOT_BITS-1:0]   den_ff   [0:QUOT_BITS];
   logic [SLOPE_BITS-1:0]  mag_x, mag_y;

   assign mag_x = x2[SLOPE_BITS-1] ? SLOPE_BITS'(-x2) : SLOPE_BITS'(x2);
   assign mag_y = y2[SLOPE_BITS-1] ? SLOPE_BITS'(-y2) : SLOPE_BITS'(y2);

   // entry: dividends and signs
   assign valid_ff[0]  = in_valid;
   assign rem_ff[0][0] = RBITS'(mag_x) << 16;
   assign rem_ff[0][1] = RBITS'(mag_y) << 16;
   assign rem_ff[0][2] = RBITS'(1) << 32;
   assign quo_ff[0][0] = '0;
   assign quo_ff[0][1] = '0;
   assign quo_ff[0][2] = '0;
   assign neg_ff[0]    = {1'b0, y2[SLOPE_BITS-1], x2[SLOPE_BITS-1]};
   assign den_ff[0]    = root;

   for (genvar j = 0; j < QUOT_BITS; j++) begin : g_stage
      logic [RBITS-1:0] dsh;
      assign dsh = RBITS'(den_ff[j]) << (QUOT_BITS - 1 - j);

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic             take;
         assign take = rem_ff[j][l] >= dsh;
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j+1][l] <= take ? rem_ff[j][l] - dsh : rem_ff[j][l];
               quo_ff[j+1][l] <= {quo_ff[j][l][QUOT_BITS-2:0], take};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            valid_ff[j+1] <= valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[j+1] <= neg_ff[j];
            den_ff[j+1] <= den_ff[j];
         end
      end
   end

   // apply the signs, truncating toward zero
   assign x1 = neg_ff[QUOT_BITS][0] ? -COMP_BITS'(quo_ff[QUOT_BITS][0])
                                     :  COMP_BITS'(quo_ff[QUOT_BITS][0]);
   assign y1 = neg_ff[QUOT_BITS][1] ? -COMP_BITS'(quo_ff[QUOT_BITS][1])
                                     :  COMP_BITS'(quo_ff[QUOT_BITS][1]);
   assign z1 = COMP_BITS'(quo_ff[QUOT_BITS][2]);
   assign out_valid = valid_ff[QUOT_BITS];
endmodule
`default_nettype wire

/* sv/vpr_rotate.sv */
// Rotation by the yaw and pitch matrix, rounding to Q1.14 and clamping; the
// last stage is the result register. Depends on vpr_pkg.
`default_nettype none
module vpr_rotate import vpr_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic signed [COMP_BITS-1:0]   x1,
   input  wire logic signed [COMP_BITS-1:0]   y1,
   input  wire logic signed [COMP_BITS-1:0]   z1,
   input  wire rot_cfg_type                   rot,
   output logic                               out_valid,
   output logic signed [DIR_BITS-1:0]         dir_x,
   output logic signed [DIR_BITS-1:0]         dir_y,
   output logic signed [DIR_BITS-1:0]         dir_z
);
   localparam int PW = COEF_BITS + COMP_BITS;
   localparam int SW = 2 * TRIG_BITS;

   logic [2:0] valid_ff;
   logic signed [COEF_BITS-1:0] sysp_ff, sycp_ff, cysp_ff, cycp_ff;
   logic signed [SW-1:0] p00_ff, p11_ff, p12_ff, p20_ff;
   logic signed [PW-1:0] p01_ff, p02_ff, p21_ff, p22_ff;
   logic signed [ACC_BITS-1:0] acc0_ff, acc1_ff, acc2_ff;
   logic signed [DIR_BITS-1:0] dx_ff, dy_ff, dz_ff;

   function automatic logic signed [DIR_BITS-1:0] to_dir(
      input logic signed [ACC_BITS-1:0] acc);
      logic signed [ACC_BITS-1:0] r;
      r = (acc + (ACC_BITS'(1) <<< 33)) >>> 34;
      if (r > ACC_BITS'(DIR_MAX)) r = ACC_BITS'(DIR_MAX);
      else if (r < -ACC_BITS'(DIR_MAX)) r = -ACC_BITS'(DIR_MAX);
      return r[DIR_BITS-1:0];
   endfunction

   // hold the matrix products of the trig registers
   always_ff @(posedge clock) begin
      sysp_ff <= rot.sin_yaw * rot.sin_pitch;
      sycp_ff <= rot.sin_yaw * rot.cos_pitch;
      cysp_ff <= rot.cos_yaw * rot.sin_pitch;
      cycp_ff <= rot.cos_yaw * rot.cos_pitch;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // products, row sums, then round and clamp
   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff  <= rot.cos_yaw * x1;
         p01_ff  <= sysp_ff * y1;
         p02_ff  <= sycp_ff * z1;
         p11_ff  <= rot.cos_pitch * y1;
         p12_ff  <= rot.sin_pitch * z1;
         p20_ff  <= rot.sin_yaw * x1;
         p21_ff  <= cysp_ff * y1;
         p22_ff  <= cycp_ff * z1;
         acc0_ff <= (ACC_BITS'(p00_ff) <<< 16) + ACC_BITS'(p01_ff) + ACC_BITS'(p02_ff);
         acc1_ff <= (ACC_BITS'(p11_ff) <<< 16) - (ACC_BITS'(p12_ff) <<< 16);
         acc2_ff <= ACC_BITS'(p21_ff) + ACC_BITS'(p22_ff) - (ACC_BITS'(p20_ff) <<< 16);
         dx_ff   <= to_dir(acc0_ff);
         dy_ff   <= to_dir(acc1_ff);
         dz_ff   <= to_dir(acc2_ff);
      end
   end

   assign out_valid = valid_ff[2];
   assign dir_x = dx_ff;
   assign dir_y = dy_ff;
   assign dir_z = dz_ff;
endmodule
`default_nettype wire
